// ===== src/pipeline_memory_stage_defines.svh =====
// Assertion macros for the memory stage of the teaching processor.
// Used by pipeline_memory_stage.sv; depends on a clk and rst_n in scope.
`ifndef PIPELINE_MEMORY_STAGE_DEFINES_SVH
`define PIPELINE_MEMORY_STAGE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define PMS_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pipeline_memory_stage assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pipeline_memory_stage assertion failed");

`else

`define PMS_ASSERT(label, ante, cons)
`define PMS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/pms_pkg.sv =====
// Shared constants and types for the memory stage of the teaching processor.
// No dependencies; used by the channel interfaces and the top level.
package pms_pkg;

    localparam logic [3:0] OP_RMMOVL = 4'd4;
    localparam logic [3:0] OP_MRMOVL = 4'd5;
    localparam logic [3:0] OP_CALL   = 4'd8;
    localparam logic [3:0] OP_RET    = 4'd9;
    localparam logic [3:0] OP_PUSHL  = 4'd10;
    localparam logic [3:0] OP_POPL   = 4'd11;

    localparam logic [1:0] STAT_ADR  = 2'd2;

    // Bytes in one word, and one byte lane memory per byte of a word.
    localparam int WORD_BYTES = 4;
    localparam int LANES      = 4;

    typedef logic [1:0]        status_t;
    typedef logic [3:0]        opcode_t;
    typedef logic [3:0]        reg_id_t;
    typedef logic signed [31:0] word_t;

    // Fields carried from the execute stage through to writeback.
    typedef struct packed {
        status_t status;
        opcode_t opcode;
        logic    cond;
        word_t   exec_value;
        word_t   operand_a;
        reg_id_t dest_exec;
        reg_id_t dest_mem;
    } pms_item_t;

endpackage

// ===== src/pms_channels.sv =====
// Valid/ready channel interfaces for the memory stage: the execute-to-memory
// input and the memory-to-writeback output. Depends on pms_pkg.
interface pms_in_if;
    logic              valid;
    logic              ready;
    pms_pkg::status_t  status_in;
    pms_pkg::opcode_t  opcode;
    logic              cond_ok;
    pms_pkg::word_t    exec_value;
    pms_pkg::word_t    operand_a;
    pms_pkg::reg_id_t  dest_exec;
    pms_pkg::reg_id_t  dest_mem;

    modport source (output valid, status_in, opcode, cond_ok, exec_value, operand_a,
                    dest_exec, dest_mem, input ready);
    modport sink   (input valid, status_in, opcode, cond_ok, exec_value, operand_a,
                    dest_exec, dest_mem, output ready);
endinterface

interface pms_out_if;
    logic              valid;
    logic              ready;
    pms_pkg::status_t  status_out;
    pms_pkg::opcode_t  opcode_out;
    logic              cond_out;
    pms_pkg::word_t    exec_value_out;
    pms_pkg::word_t    operand_a_out;
    pms_pkg::word_t    mem_value;
    pms_pkg::reg_id_t  dest_exec_out;
    pms_pkg::reg_id_t  dest_mem_out;

    modport source (output valid, status_out, opcode_out, cond_out, exec_value_out,
                    operand_a_out, mem_value, dest_exec_out, dest_mem_out, input ready);
    modport sink   (input valid, status_out, opcode_out, cond_out, exec_value_out,
                    operand_a_out, mem_value, dest_exec_out, dest_mem_out, output ready);
endinterface

// ===== src/pipeline_memory_stage.sv =====
// Memory stage of a five-stage 32-bit teaching processor: top level.
// Depends on pms_pkg, pms_channels.sv, pms_ram and pipeline_memory_stage_defines.svh.
//
// ex_mem is the execute-to-memory channel and mem_wb the memory-to-writeback
// channel; a transfer happens on a rising edge with valid and ready high. Each
// instruction gives exactly one result, in order. rmmovl, call and pushl store
// operand_a big-endian at exec_value; mrmovl loads from exec_value, ret and popl
// from operand_a. A negative address, or one whose word runs past MEM_BYTES,
// leaves memory alone and reports the address error status with a zero value.
//
// The store is split into four byte-lane RAMs, so any word, aligned or not, is
// one access to each lane, issued at the input transfer. The lane data and the
// read stage are registered at that transfer; the result is then formed into the
// output register, which drives mem_wb.valid, once that register is free or taken.
// One instruction is taken every cycle while the receiver keeps up.
// After reset a clearing pass zeroes one row of all four lanes a cycle, over all
// ceil(MEM_BYTES/4) rows (1024 at the default), with ex_mem.ready low. When
// mem_wb stalls, the output register and the read stage each hold one
// instruction before ex_mem.ready drops.
`include "pipeline_memory_stage_defines.svh"

module pipeline_memory_stage #(
    parameter int MEM_BYTES = 4096
) (
    input  logic     clk,
    input  logic     rst_n,
    pms_in_if.sink   ex_mem,
    pms_out_if.source mem_wb
);

    localparam int ROWS  = (MEM_BYTES + pms_pkg::WORD_BYTES - 1) / pms_pkg::WORD_BYTES;
    localparam int ROW_W = $clog2(ROWS);
    // Highest start address whose whole word still lies inside the store.
    localparam int LIMIT = MEM_BYTES - pms_pkg::WORD_BYTES;

    // Clearing pass after reset.
    logic             clear_active_reg;
    logic             clear_active_next;
    logic [ROW_W-1:0] clear_row_reg;
    logic [ROW_W-1:0] clear_row_next;

    // Read stage: the instruction whose lane reads are in flight.
    logic                s1_valid_reg;
    logic                s1_valid_next;
    pms_pkg::pms_item_t  s1_item_reg;
    logic [1:0]          s1_off_reg;
    logic                s1_rd_reg;
    logic                s1_err_reg;
    pms_pkg::pms_item_t  s1_result;

    // Output register.
    logic                out_valid_reg;
    logic                out_valid_next;
    pms_pkg::pms_item_t  out_item_reg;
    pms_pkg::word_t      out_mem_value_reg;

    logic                accept;
    logic                s1_move;
    logic                is_wr;
    logic                is_rd;
    logic                addr_ok;
    logic [31:0]         addr;
    logic [1:0]          off;
    logic [ROW_W-1:0]    base_row;
    pms_pkg::word_t      word_read;

    logic [ROW_W-1:0]    lane_row   [pms_pkg::LANES];
    logic [ROW_W-1:0]    lane_waddr [pms_pkg::LANES];
    logic [7:0]          lane_wdata [pms_pkg::LANES];
    logic [7:0]          lane_rdata [pms_pkg::LANES];
    logic                lane_we;
    logic                lane_re;

    // Address selection and range check.
    always_comb
    begin
        is_wr = (ex_mem.opcode == pms_pkg::OP_RMMOVL) || (ex_mem.opcode == pms_pkg::OP_CALL)
             || (ex_mem.opcode == pms_pkg::OP_PUSHL);
        is_rd = (ex_mem.opcode == pms_pkg::OP_MRMOVL) || (ex_mem.opcode == pms_pkg::OP_RET)
             || (ex_mem.opcode == pms_pkg::OP_POPL);
        if ((ex_mem.opcode == pms_pkg::OP_POPL) || (ex_mem.opcode == pms_pkg::OP_RET))
        begin
            addr = ex_mem.operand_a;
        end
        else
        begin
            addr = ex_mem.exec_value;
        end
        addr_ok  = !addr[31] && (addr[30:0] <= 31'(LIMIT));
        off      = addr[1:0];
        base_row = addr[ROW_W+1:2];
    end

    // Per-lane row and write byte. Byte i of the word, most significant
    // first, sits at address addr+i, which is in lane (off+i) mod 4; lanes
    // below the starting lane therefore fall in the next row.
    always_comb
    begin
        logic [1:0] byte_idx;
        logic [1:0] byte_sel;
        for (int b = 0; b < pms_pkg::LANES; b++)
        begin
            byte_idx    = 2'(b) - off;
            byte_sel    = 2'd3 - byte_idx;
            lane_row[b] = base_row + ROW_W'(2'(b) < off);
            if (clear_active_reg)
            begin
                lane_waddr[b] = clear_row_reg;
                lane_wdata[b] = 8'd0;
            end
            else
            begin
                lane_waddr[b] = lane_row[b];
                lane_wdata[b] = ex_mem.operand_a[{byte_sel, 3'b000} +: 8];
            end
        end
    end

    assign ex_mem.ready = !clear_active_reg && (!s1_valid_reg || s1_move);
    assign accept       = ex_mem.valid && ex_mem.ready;
    assign s1_move      = s1_valid_reg && (!out_valid_reg || mem_wb.ready);
    assign lane_we      = clear_active_reg || (accept && is_wr && addr_ok);
    assign lane_re      = accept && is_rd && addr_ok;

    for (genvar g = 0; g < pms_pkg::LANES; g++)
    begin : g_lane
        pms_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_lane (
            .clk   (clk),
            .we    (lane_we),
            .waddr (lane_waddr[g]),
            .wdata (lane_wdata[g]),
            .re    (lane_re),
            .raddr (lane_row[g]),
            .rdata (lane_rdata[g])
        );
    end

    // Reassemble the big-endian word from the rotated lanes.
    always_comb
    begin
        word_read = '0;
        for (int i = 0; i < pms_pkg::WORD_BYTES; i++)
        begin
            word_read[8*(3-i) +: 8] = lane_rdata[2'(2'(i) + s1_off_reg)];
        end
    end

    // An address error replaces the incoming status on the way out.
    always_comb
    begin
        s1_result = s1_item_reg;
        if (s1_err_reg)
        begin
            s1_result.status = pms_pkg::STAT_ADR;
        end
    end

    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_row_next    = clear_row_reg;
        if (clear_active_reg)
        begin
            clear_row_next = clear_row_reg + ROW_W'(1);
            if (clear_row_reg == ROW_W'(ROWS - 1))
            begin
                clear_active_next = 1'b0;
            end
        end
        s1_valid_next  = accept || (s1_valid_reg && !s1_move);
        out_valid_next = s1_move || (out_valid_reg && !mem_wb.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_row_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_row_reg    <= clear_row_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= '{status:     ex_mem.status_in,
                             opcode:     ex_mem.opcode,
                             cond:       ex_mem.cond_ok,
                             exec_value: ex_mem.exec_value,
                             operand_a:  ex_mem.operand_a,
                             dest_exec:  ex_mem.dest_exec,
                             dest_mem:   ex_mem.dest_mem};
            s1_off_reg  <= off;
            s1_rd_reg   <= is_rd && addr_ok;
            s1_err_reg  <= (is_rd || is_wr) && !addr_ok;
        end
        if (s1_move)
        begin
            out_item_reg      <= s1_result;
            out_mem_value_reg <= s1_rd_reg ? word_read : '0;
        end
    end

    assign mem_wb.valid          = out_valid_reg;
    assign mem_wb.status_out     = out_item_reg.status;
    assign mem_wb.opcode_out     = out_item_reg.opcode;
    assign mem_wb.cond_out       = out_item_reg.cond;
    assign mem_wb.exec_value_out = out_item_reg.exec_value;
    assign mem_wb.operand_a_out  = out_item_reg.operand_a;
    assign mem_wb.mem_value      = out_mem_value_reg;
    assign mem_wb.dest_exec_out  = out_item_reg.dest_exec;
    assign mem_wb.dest_mem_out   = out_item_reg.dest_mem;

    // No instruction is taken while the store is being cleared.
    `PMS_ASSERT(a_no_accept_in_clear, clear_active_reg, !ex_mem.ready)
    // An out-of-range access never writes the store.
    `PMS_ASSERT(a_no_bad_write, accept && !addr_ok && !clear_active_reg, !lane_we)
    // A waiting instruction in the read stage is kept while the output stalls.
    `PMS_ASSERT_NEXT(a_s1_held, s1_valid_reg && out_valid_reg && !mem_wb.ready,
                     s1_valid_reg && $stable(s1_off_reg))
    // Instructions that do not load report a zero memory value.
    `PMS_ASSERT(a_zero_without_load,
                out_valid_reg && (out_item_reg.opcode != pms_pkg::OP_MRMOVL)
                && (out_item_reg.opcode != pms_pkg::OP_RET)
                && (out_item_reg.opcode != pms_pkg::OP_POPL),
                out_mem_value_reg == '0)

endmodule

// ===== src/pms_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
// No dependencies; the read data holds until the next read is enabled.
module pms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== tb/pipeline_memory_stage_tb.sv =====
// Self-checking testbench for the memory stage of the teaching processor.
// Uses pms_pkg, the pms_in_if/pms_out_if channel interfaces and the
// pipeline_memory_stage top level; needs nothing else.
module pipeline_memory_stage_tb;

    localparam int MEM_BYTES = 4096;

    // Directed instructions come first, then this many random ones.
    localparam int RANDOM_INSTRS = 925;

    // The clearing pass runs first after reset. The limit leaves ample headroom
    // for it and for a slow but correct run of every instruction.
    localparam int CYCLE_LIMIT = 400000;

    // One memory-to-writeback result as the stage should deliver it.
    typedef struct packed {
        pms_pkg::status_t status;
        pms_pkg::opcode_t opcode;
        logic             cond;
        pms_pkg::word_t   exec_value;
        pms_pkg::word_t   operand_a;
        pms_pkg::word_t   mem_value;
        pms_pkg::reg_id_t dest_exec;
        pms_pkg::reg_id_t dest_mem;
    } wb_result_t;

    logic clk;
    logic rst_n = 1'b0;

    pms_in_if  ex_mem_ch ();
    pms_out_if mem_wb_ch ();

    // Testbench-side drive variables. They start at known values so that no
    // input of the stage is ever unknown, even before the first falling edge.
    logic               drv_valid = 1'b0;
    pms_pkg::pms_item_t drv_item  = '0;
    logic               wb_ready  = 1'b0;

    assign ex_mem_ch.valid      = drv_valid;
    assign ex_mem_ch.status_in  = drv_item.status;
    assign ex_mem_ch.opcode     = drv_item.opcode;
    assign ex_mem_ch.cond_ok    = drv_item.cond;
    assign ex_mem_ch.exec_value = drv_item.exec_value;
    assign ex_mem_ch.operand_a  = drv_item.operand_a;
    assign ex_mem_ch.dest_exec  = drv_item.dest_exec;
    assign ex_mem_ch.dest_mem   = drv_item.dest_mem;
    assign mem_wb_ch.ready      = wb_ready;

    // Instructions waiting to be offered, and results still owed by the stage.
    pms_pkg::pms_item_t instr_queue [$];
    wb_result_t         expected_writebacks [$];

    // Our own copy of the byte store, kept in step with accepted instructions.
    logic [7:0] shadow_bytes [MEM_BYTES];

    int   accepted_count = 0;
    int   result_count   = 0;
    int   error_count    = 0;
    int   cycle_count    = 0;
    logic offer_taken    = 1'b0;
    int   gap_left       = 0;
    int   stall_left     = 0;
    int   holdoff_left   = 0;
    logic holdoff_done   = 1'b0;

    wb_result_t seen_wb;
    wb_result_t want_wb;

    pipeline_memory_stage #(
        .MEM_BYTES (MEM_BYTES)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .ex_mem (ex_mem_ch),
        .mem_wb (mem_wb_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the writeback result of one instruction and applies any store
    // to the shadow byte store. The address is signed: a negative address, or
    // one whose four bytes run past the end of the store, is an address error
    // that leaves the store untouched and reads as zero. An incoming error
    // status does not suppress the access; it merely passes through.
    function automatic wb_result_t predict_writeback(input pms_pkg::pms_item_t ins);
        wb_result_t res;
        longint     addr;
        logic       is_store;
        logic       is_load;
        int         b;
        is_store = (ins.opcode == pms_pkg::OP_RMMOVL) || (ins.opcode == pms_pkg::OP_CALL) ||
                   (ins.opcode == pms_pkg::OP_PUSHL);
        is_load  = (ins.opcode == pms_pkg::OP_MRMOVL) || (ins.opcode == pms_pkg::OP_RET) ||
                   (ins.opcode == pms_pkg::OP_POPL);
        addr = (ins.opcode == pms_pkg::OP_RET || ins.opcode == pms_pkg::OP_POPL) ?
               longint'(ins.operand_a) : longint'(ins.exec_value);
        res.status     = ins.status;
        res.opcode     = ins.opcode;
        res.cond       = ins.cond;
        res.exec_value = ins.exec_value;
        res.operand_a  = ins.operand_a;
        res.mem_value  = '0;
        res.dest_exec  = ins.dest_exec;
        res.dest_mem   = ins.dest_mem;
        if (is_store || is_load)
        begin
            if (addr < 0 || addr + pms_pkg::WORD_BYTES > MEM_BYTES)
            begin
                res.status = pms_pkg::STAT_ADR;
            end
            else
            begin
                // Big-endian: the most significant byte sits at the lowest address.
                for (b = 0; b < pms_pkg::WORD_BYTES; b++)
                begin
                    if (is_store)
                        shadow_bytes[int'(addr) + b] = ins.operand_a[31 - 8 * b -: 8];
                    else
                        res.mem_value = {res.mem_value[23:0], shadow_bytes[int'(addr) + b]};
                end
            end
        end
        return res;
    endfunction

    // Every fourth block of 128 transfers runs with no idling on either side.
    function automatic logic flat_out_phase();
        return ((accepted_count >> 7) & 3) == 3;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (flat_out_phase())
            return 0;
        else if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Addresses cluster in two small windows so that loads often find earlier
    // stores, including unaligned overlaps and the last few bytes of the store.
    function automatic pms_pkg::word_t pick_address();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return pms_pkg::word_t'($urandom_range(0, 47));
        else if (roll < 60)
            return pms_pkg::word_t'(MEM_BYTES - 20 + $urandom_range(0, 19));
        else if (roll < 85)
            return pms_pkg::word_t'($urandom_range(0, MEM_BYTES - pms_pkg::WORD_BYTES));
        else if (roll < 92)
            return pms_pkg::word_t'($urandom);
        else
            return -pms_pkg::word_t'($urandom_range(1, 8));
    endfunction

    function automatic pms_pkg::pms_item_t random_instruction();
        pms_pkg::pms_item_t ins;
        ins.status     = pms_pkg::status_t'($urandom_range(0, 3));
        ins.cond       = 1'($urandom_range(0, 1));
        ins.dest_exec  = pms_pkg::reg_id_t'($urandom_range(0, 15));
        ins.dest_mem   = pms_pkg::reg_id_t'($urandom_range(0, 15));
        ins.exec_value = pms_pkg::word_t'($urandom);
        ins.operand_a  = pms_pkg::word_t'($urandom);
        if ($urandom_range(0, 99) < 15)
        begin
            // Noise: any code at all, with fully random words.
            ins.opcode = pms_pkg::opcode_t'($urandom_range(0, 15));
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: ins.opcode = pms_pkg::OP_RMMOVL;
                1: ins.opcode = pms_pkg::OP_MRMOVL;
                2: ins.opcode = pms_pkg::OP_CALL;
                3: ins.opcode = pms_pkg::OP_RET;
                4: ins.opcode = pms_pkg::OP_PUSHL;
                default: ins.opcode = pms_pkg::OP_POPL;
            endcase
            if (ins.opcode == pms_pkg::OP_RET || ins.opcode == pms_pkg::OP_POPL)
                ins.operand_a = pick_address();
            else
                ins.exec_value = pick_address();
        end
        return ins;
    endfunction

    task automatic add_instr(input pms_pkg::status_t st, input pms_pkg::opcode_t op,
                             input pms_pkg::word_t ve, input pms_pkg::word_t va);
        pms_pkg::pms_item_t ins;
        ins.status     = st;
        ins.opcode     = op;
        ins.cond       = 1'($urandom_range(0, 1));
        ins.exec_value = ve;
        ins.operand_a  = va;
        ins.dest_exec  = pms_pkg::reg_id_t'($urandom_range(0, 15));
        ins.dest_mem   = pms_pkg::reg_id_t'($urandom_range(0, 15));
        instr_queue.push_back(ins);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR: result %0d: %s", result_count, msg);
        error_count++;
    endtask

    // Sender. A new instruction is put on the channel at the falling edge once
    // the previous one has been transferred, after a random gap. Valid stays
    // high across back-to-back transfers and is assigned at most once per edge.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
        end
        else if (!drv_valid || offer_taken)
        begin
            offer_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                drv_valid <= 1'b0;
            end
            else if (instr_queue.size() > 0)
            begin
                drv_item  <= instr_queue.pop_front();
                drv_valid <= 1'b1;
                gap_left = pick_idle();
            end
            else
            begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Input transfers are seen at the rising edge. The prediction is made in
    // transfer order, which is the order in which the stage touches memory.
    always @(posedge clk)
    begin
        if (rst_n && drv_valid && ex_mem_ch.ready)
        begin
            expected_writebacks.push_back(predict_writeback(drv_item));
            accepted_count++;
            offer_taken = 1'b1;
        end
    end

    // Receiver. Ready drops for random stalls, and once, part-way through the
    // run, for a long hold-off while the sender keeps offering, so that the
    // stage fills its two slots and has to stall its input.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            wb_ready <= 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left--;
            wb_ready <= 1'b0;
        end
        else if (!holdoff_done && accepted_count >= 300)
        begin
            holdoff_done = 1'b1;
            holdoff_left = 120;
            wb_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            wb_ready <= 1'b0;
        end
        else
        begin
            wb_ready <= 1'b1;
            stall_left = ($urandom_range(0, 99) < 20) ? pick_idle() : 0;
        end
    end

    // Output monitor: each result transfer is checked field by field against
    // the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && mem_wb_ch.valid && wb_ready)
        begin
            seen_wb.status     = mem_wb_ch.status_out;
            seen_wb.opcode     = mem_wb_ch.opcode_out;
            seen_wb.cond       = mem_wb_ch.cond_out;
            seen_wb.exec_value = mem_wb_ch.exec_value_out;
            seen_wb.operand_a  = mem_wb_ch.operand_a_out;
            seen_wb.mem_value  = mem_wb_ch.mem_value;
            seen_wb.dest_exec  = mem_wb_ch.dest_exec_out;
            seen_wb.dest_mem   = mem_wb_ch.dest_mem_out;
            if (expected_writebacks.size() == 0)
            begin
                report_mismatch("result arrived with none outstanding");
            end
            else
            begin
                want_wb = expected_writebacks.pop_front();
                if (seen_wb.status !== want_wb.status)
                    report_mismatch($sformatf("status_out %h, expected %h",
                                              seen_wb.status, want_wb.status));
                if (seen_wb.opcode !== want_wb.opcode)
                    report_mismatch($sformatf("opcode_out %h, expected %h",
                                              seen_wb.opcode, want_wb.opcode));
                if (seen_wb.cond !== want_wb.cond)
                    report_mismatch($sformatf("cond_out %b, expected %b",
                                              seen_wb.cond, want_wb.cond));
                if (seen_wb.exec_value !== want_wb.exec_value)
                    report_mismatch($sformatf("exec_value_out %h, expected %h",
                                              seen_wb.exec_value, want_wb.exec_value));
                if (seen_wb.operand_a !== want_wb.operand_a)
                    report_mismatch($sformatf("operand_a_out %h, expected %h",
                                              seen_wb.operand_a, want_wb.operand_a));
                if (seen_wb.mem_value !== want_wb.mem_value)
                    report_mismatch($sformatf("mem_value %h, expected %h",
                                              seen_wb.mem_value, want_wb.mem_value));
                if (seen_wb.dest_exec !== want_wb.dest_exec)
                    report_mismatch($sformatf("dest_exec_out %h, expected %h",
                                              seen_wb.dest_exec, want_wb.dest_exec));
                if (seen_wb.dest_mem !== want_wb.dest_mem)
                    report_mismatch($sformatf("dest_mem_out %h, expected %h",
                                              seen_wb.dest_mem, want_wb.dest_mem));
            end
            result_count++;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        int op;
        for (i = 0; i < MEM_BYTES; i++)
            shadow_bytes[i] = 8'h00;

        // Store and load back at the bottom of memory; an incoming bad
        // instruction status passes through an access that succeeds.
        add_instr(2'd0, pms_pkg::OP_RMMOVL, 32'sd0, 32'h8000_0001);
        add_instr(2'd3, pms_pkg::OP_MRMOVL, 32'sd0, 32'h7FFF_FFFF);
        // The last word that fits, written by push and read back by pop.
        add_instr(2'd1, pms_pkg::OP_PUSHL, pms_pkg::word_t'(MEM_BYTES - 4), 32'hDEAD_BEEF);
        add_instr(2'd0, pms_pkg::OP_POPL, 32'hFFFF_FFFF, pms_pkg::word_t'(MEM_BYTES - 4));
        // One byte past the end, a negative address and the most negative and
        // most positive words: all address errors, whatever came in.
        add_instr(2'd0, pms_pkg::OP_CALL, pms_pkg::word_t'(MEM_BYTES - 3), 32'h1234_5678);
        add_instr(2'd2, pms_pkg::OP_RET, 32'sd0, pms_pkg::word_t'(MEM_BYTES - 3));
        add_instr(2'd0, pms_pkg::OP_MRMOVL, -32'sd1, 32'sd0);
        add_instr(2'd1, pms_pkg::OP_RMMOVL, 32'h8000_0000, 32'hFFFF_FFFF);
        add_instr(2'd3, pms_pkg::OP_POPL, 32'sd0, 32'h7FFF_FFFF);
        // An unaligned store overlapping the first word, read back across the
        // seam from both sides.
        add_instr(2'd0, pms_pkg::OP_RMMOVL, 32'sd1, 32'hA1B2_C3D4);
        add_instr(2'd0, pms_pkg::OP_MRMOVL, 32'sd0, 32'sd0);
        add_instr(2'd0, pms_pkg::OP_RET, 32'sd0, 32'sd3);
        // A word never written reads as zero after the clearing pass.
        add_instr(2'd0, pms_pkg::OP_MRMOVL, 32'sd100, 32'sd0);
        add_instr(2'd0, pms_pkg::OP_CALL, 32'sd8, 32'h0000_00FF);
        // Codes with no memory access never raise an address error, even with
        // addresses that would be out of range.
        for (op = 0; op < 16; op++)
        begin
            if (op != pms_pkg::OP_RMMOVL && op != pms_pkg::OP_MRMOVL &&
                op != pms_pkg::OP_CALL && op != pms_pkg::OP_RET &&
                op != pms_pkg::OP_PUSHL && op != pms_pkg::OP_POPL)
                add_instr(pms_pkg::status_t'(op % 4), pms_pkg::opcode_t'(op),
                          (op % 2 == 0) ? 32'hFFFF_FFFF : 32'h8000_0000, 32'h7FFF_FFFF);
        end

        for (i = 0; i < RANDOM_INSTRS; i++)
            instr_queue.push_back(random_instruction());

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every instruction to be transferred, then for every result.
        while (instr_queue.size() != 0 || drv_valid)
            @(posedge clk);
        while (expected_writebacks.size() != 0)
            @(posedge clk);
        // Run on to catch any stray result beyond those predicted.
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
